@@ rtl/core/gwd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwd_pkg
// Shared types, constants and helpers of the six-mode antenna response block.
// ----------------------------------------------------------------------------
package gwd_pkg;

  // Angle precision kept at the trig inputs; the mask clears bits below it, none at 32 bits.
  localparam int ANGLE_BITS = 32;
  localparam logic [31:0] ANGLE_MASK = 32'(64'hFFFF_FFFF << (32 - ANGLE_BITS));

  localparam logic [31:0]        PI_Q30    = 32'hC90F_DAA2;
  localparam logic signed [31:0] SQRT2_Q30 = 32'sd1518500250;
  localparam logic [30:0]        Q_ONE     = 31'h4000_0000;

  // Horner steps of the series; the sine chain has one step fewer.
  localparam int NUM_STEPS = 6;
  localparam logic [7:0] COS_DIV [NUM_STEPS] =
    '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [7:0] SIN_DIV [NUM_STEPS-1] =
    '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  // floor(2^32 / k): quotient estimate is at most one low
  localparam logic [31:0] COS_RECIP [NUM_STEPS] = '{
    32'(64'h1_0000_0000 / 132), 32'(64'h1_0000_0000 / 90),
    32'(64'h1_0000_0000 / 56),  32'(64'h1_0000_0000 / 30),
    32'(64'h1_0000_0000 / 12),  32'(64'h1_0000_0000 / 2)};
  localparam logic [31:0] SIN_RECIP [NUM_STEPS-1] = '{
    32'(64'h1_0000_0000 / 110), 32'(64'h1_0000_0000 / 72),
    32'(64'h1_0000_0000 / 42),  32'(64'h1_0000_0000 / 20),
    32'(64'h1_0000_0000 / 6)};

  typedef enum logic [2:0] {
    REG_XX, REG_XY, REG_XZ, REG_YY, REG_YZ, REG_ZZ
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] xx;
    logic signed [31:0] xy;
    logic signed [31:0] xz;
    logic signed [31:0] yy;
    logic signed [31:0] yz;
    logic signed [31:0] zz;
  } tensor_t;

  // One basis vector component, Q2.30 with headroom.
  typedef logic signed [32:0] comp_t;

  typedef struct packed {
    logic [31:0]        right_ascension;
    logic signed [31:0] declination;
    logic [31:0]        polarisation;
    logic [31:0]        sidereal_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] resp_plus;
    logic signed [31:0] resp_cross;
    logic signed [31:0] resp_breathing;
    logic signed [31:0] resp_longitudinal;
    logic signed [31:0] resp_vector_x;
    logic signed [31:0] resp_vector_y;
  } out_item_t;

  localparam logic signed [39:0] SAT_HI = 40'sd2147483647;
  localparam logic signed [39:0] SAT_LO = -40'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/gw_detector_six_mode_response_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gw_detector_six_mode_response_top
// Six-mode antenna response of a gravitational-wave detector.
// ----------------------------------------------------------------------------
// Usage:
//   - Input channel (item_valid / item_ready / item_data) takes one sky and
//     time sample per item: right ascension, declination, polarisation and
//     sidereal time as binary angles.
//   - Result channel (result_valid / result_ready / result_data) returns the
//     plus, cross, breathing, longitudinal (times sqrt2), vector x and
//     vector y responses in Q2.30, saturated, one item per input item.
//   - Configuration port: cfg_we writes cfg_data into the tensor register
//     picked by cfg_index (xx, xy, xz, yy, yz, zz); other indexes are
//     dropped. Write only while no item is in flight.
//   - One item enters per cycle unless a held result stalls the pipeline. Depth
//     is set by the sine/cosine series: six Horner steps of multiply,
//     reciprocal multiply and correction, three stages each.
//   - Reset clears all valid bits and the tensor registers to zero.
//   - A stall on result_ready freezes the whole pipeline in place; item_ready
//     drops only while a finished item waits and the receiver holds off.
// ----------------------------------------------------------------------------
module gw_detector_six_mode_response_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  gwd_pkg::in_item_t  item_data,
  output logic               result_valid,
  input  logic               result_ready,
  output gwd_pkg::out_item_t result_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  gwd_pkg::tensor_t tensor;

  // Advance every stage unless the output holds an item nobody takes
  logic en;
  assign en         = !result_valid || result_ready;
  assign item_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      tensor <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gwd_pkg::REG_XX: tensor.xx <= cfg_data;
        gwd_pkg::REG_XY: tensor.xy <= cfg_data;
        gwd_pkg::REG_XZ: tensor.xz <= cfg_data;
        gwd_pkg::REG_YY: tensor.yy <= cfg_data;
        gwd_pkg::REG_YZ: tensor.yz <= cfg_data;
        gwd_pkg::REG_ZZ: tensor.zz <= cfg_data;
        default: ;
      endcase
    end
  end

  logic        in_take;
  logic [31:0] hour_angle;

  assign in_take    = item_valid && item_ready;
  // Hour angle wraps modulo one turn
  assign hour_angle = item_data.sidereal_time - item_data.right_ascension;

  logic               vg, vd, vp;
  logic signed [31:0] sg, cg, sd, cd, sp, cp;

  gwd_sincos u_trig_ha (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_take),
    .angle(hour_angle),
    .out_valid(vg), .sin_q(sg), .cos_q(cg)
  );

  gwd_sincos u_trig_dec (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_take),
    .angle(unsigned'(item_data.declination)),
    .out_valid(vd), .sin_q(sd), .cos_q(cd)
  );

  gwd_sincos u_trig_psi (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_take),
    .angle(item_data.polarisation),
    .out_valid(vp), .sin_q(sp), .cos_q(cp)
  );

  logic           vb;
  gwd_pkg::comp_t vx [3];
  gwd_pkg::comp_t vy [3];
  gwd_pkg::comp_t vz [3];

  gwd_basis u_basis (
    .clk(clk), .rst(rst), .en(en), .in_valid(vg && vd && vp),
    .sg(sg), .cg(cg), .sd(sd), .cd(cd), .sp(sp), .cp(cp),
    .out_valid(vb), .vx(vx), .vy(vy), .vz(vz)
  );

  gwd_contract u_contract (
    .clk(clk), .rst(rst), .en(en), .in_valid(vb),
    .tensor(tensor), .vx(vx), .vy(vy), .vz(vz),
    .out_valid(result_valid), .result(result_data)
  );

endmodule

@@ rtl/core/gwd_sincos.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwd_sincos
// Pipelined sine and cosine of a binary angle: octant fold, radian scale,
// Horner series with reciprocal-multiply division, quadrant signs.
// ----------------------------------------------------------------------------
module gwd_sincos (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [31:0]        angle,
  output logic               out_valid,
  output logic signed [31:0] sin_q,
  output logic signed [31:0] cos_q
);

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [1:0]  quad;
    logic        swap;
  } side_t;

  // Finish a step: correct the quotient estimate by one, then 1 - q.
  function automatic logic [30:0] horner_fix(input logic [29:0] v,
                                             input logic [29:0] q0,
                                             input logic [7:0] k);
    logic [37:0] rem;
    logic [29:0] q;
    rem = 38'(v) - 38'(q0) * 38'(k);
    q   = (rem >= 38'(k)) ? q0 + 30'd1 : q0;
    return gwd_pkg::Q_ONE - 31'(q);
  endfunction

  // Fold to first octant
  logic [31:0] a_m;
  logic [29:0] r_raw, r_fold;
  logic        fold;

  assign a_m    = angle & gwd_pkg::ANGLE_MASK;
  assign r_raw  = a_m[29:0];
  assign fold   = r_raw > 30'h2000_0000;
  assign r_fold = fold ? 30'(31'h4000_0000 - 31'(r_raw)) : r_raw;

  logic        v1, v2;
  logic [1:0]  quad1, quad2;
  logic        swap1, swap2;
  logic [29:0] r1, x2s;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quad1 <= a_m[31:30];
      swap1 <= fold;
      r1    <= r_fold;
    end
  end

  // Radians in Q30
  logic [61:0] px;
  assign px = 62'(r1) * 62'(gwd_pkg::PI_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quad2 <= quad1;
      swap2 <= swap1;
      x2s   <= px[60:31];
    end
  end

  // Square of the argument
  logic [59:0] pxx;
  assign pxx = 60'(x2s) * 60'(x2s);

  side_t       side_b [gwd_pkg::NUM_STEPS+1];
  logic [30:0] tc_b   [gwd_pkg::NUM_STEPS+1];
  logic [30:0] ts_b   [gwd_pkg::NUM_STEPS+1];
  logic        v_b    [gwd_pkg::NUM_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b[0] <= 1'b0;
    end else if (en) begin
      v_b[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_b[0] <= '{x: x2s, x2: pxx[59:30], quad: quad2, swap: swap2};
      tc_b[0]   <= gwd_pkg::Q_ONE;
      ts_b[0]   <= gwd_pkg::Q_ONE;
    end
  end

  for (genvar i = 0; i < gwd_pkg::NUM_STEPS; i++) begin : g_step
    side_t       side_m, side_r;
    logic        vm, vr;
    logic [60:0] prod_c;
    logic [61:0] rc;
    logic [29:0] pc_m, pc_r, qc_r;

    assign prod_c = 61'(side_b[i].x2) * 61'(tc_b[i]);
    assign rc     = 62'(pc_m) * 62'(gwd_pkg::COS_RECIP[i]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vm       <= 1'b0;
        vr       <= 1'b0;
        v_b[i+1] <= 1'b0;
      end else if (en) begin
        vm       <= v_b[i];
        vr       <= vm;
        v_b[i+1] <= vr;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_m      <= side_b[i];
        pc_m        <= prod_c[59:30];
        side_r      <= side_m;
        pc_r        <= pc_m;
        qc_r        <= rc[61:32];
        side_b[i+1] <= side_r;
        tc_b[i+1]   <= horner_fix(pc_r, qc_r, gwd_pkg::COS_DIV[i]);
      end
    end

    if (i < gwd_pkg::NUM_STEPS - 1) begin : g_sin_step
      logic [60:0] prod_s;
      logic [61:0] rs;
      logic [29:0] ps_m, ps_r, qs_r;

      assign prod_s = 61'(side_b[i].x2) * 61'(ts_b[i]);
      assign rs     = 62'(ps_m) * 62'(gwd_pkg::SIN_RECIP[i]);

      always_ff @(posedge clk) begin
        if (en) begin
          ps_m      <= prod_s[59:30];
          ps_r      <= ps_m;
          qs_r      <= rs[61:32];
          ts_b[i+1] <= horner_fix(ps_r, qs_r, gwd_pkg::SIN_DIV[i]);
        end
      end
    end else begin : g_sin_last
      // Multiply by x and hold while the cosine chain finishes
      logic [60:0] prod_s;
      logic [30:0] ps_m, ps_r;

      assign prod_s = 61'(side_b[i].x) * 61'(ts_b[i]);

      always_ff @(posedge clk) begin
        if (en) begin
          ps_m      <= prod_s[60:30];
          ps_r      <= ps_m;
          ts_b[i+1] <= ps_r;
        end
      end
    end
  end

  // Undo the fold: octant swap, then quadrant signs
  logic signed [31:0] so, co, sin_n, cos_n;
  side_t              side_f;

  assign side_f = side_b[gwd_pkg::NUM_STEPS];
  assign so = side_f.swap ? {1'b0, tc_b[gwd_pkg::NUM_STEPS]}
                          : {1'b0, ts_b[gwd_pkg::NUM_STEPS]};
  assign co = side_f.swap ? {1'b0, ts_b[gwd_pkg::NUM_STEPS]}
                          : {1'b0, tc_b[gwd_pkg::NUM_STEPS]};

  always_comb begin
    unique case (side_f.quad)
      2'd0: begin
        sin_n = so;
        cos_n = co;
      end
      2'd1: begin
        sin_n = co;
        cos_n = -so;
      end
      2'd2: begin
        sin_n = -so;
        cos_n = -co;
      end
      default: begin
        sin_n = -co;
        cos_n = so;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_b[gwd_pkg::NUM_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q <= sin_n;
      cos_q <= cos_n;
    end
  end

endmodule

@@ rtl/core/gwd_basis.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwd_basis
// Two-stage build of the wave-frame basis vectors X, Y and Z.
// ----------------------------------------------------------------------------
module gwd_basis (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] sg,
  input  logic signed [31:0] cg,
  input  logic signed [31:0] sd,
  input  logic signed [31:0] cd,
  input  logic signed [31:0] sp,
  input  logic signed [31:0] cp,
  output logic               out_valid,
  output gwd_pkg::comp_t     vx [3],
  output gwd_pkg::comp_t     vy [3],
  output gwd_pkg::comp_t     vz [3]
);

  function automatic logic signed [31:0] qm(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p[61:30];
  endfunction

  logic               v1;
  logic signed [31:0] cp_sg, sp_cg, sp_sg, cp_cg, sp_cd, cp_cd, cd_cg, cd_sg, sd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp_sg <= qm(cp, sg);
      sp_cg <= qm(sp, cg);
      sp_sg <= qm(sp, sg);
      cp_cg <= qm(cp, cg);
      sp_cd <= qm(sp, cd);
      cp_cd <= qm(cp, cd);
      cd_cg <= qm(cd, cg);
      cd_sg <= qm(cd, sg);
      sd1   <= sd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx[0] <= -33'(cp_sg) - 33'(qm(sp_cg, sd1));
      vx[1] <= -33'(cp_cg) + 33'(qm(sp_sg, sd1));
      vx[2] <= 33'(sp_cd);
      vy[0] <= 33'(sp_sg) - 33'(qm(cp_cg, sd1));
      vy[1] <= 33'(sp_cg) + 33'(qm(cp_sg, sd1));
      vy[2] <= 33'(cp_cd);
      vz[0] <= -33'(cd_cg);
      vz[1] <= 33'(cd_sg);
      vz[2] <= -33'(sd1);
    end
  end

endmodule

@@ rtl/core/gwd_contract.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwd_contract
// Contract the basis vectors with the detector tensor, sum and saturate the
// six responses.
// ----------------------------------------------------------------------------
module gwd_contract (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  gwd_pkg::tensor_t    tensor,
  input  gwd_pkg::comp_t      vx [3],
  input  gwd_pkg::comp_t      vy [3],
  input  gwd_pkg::comp_t      vz [3],
  output logic                out_valid,
  output gwd_pkg::out_item_t  result
);

  // Vector pairs (a . D b): XDX YDY XDY YDX ZDZ XDZ ZDX YDZ ZDY
  localparam logic [1:0] PA [9] = '{2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd1, 2'd2};
  localparam logic [1:0] PB [9] = '{2'd0, 2'd1, 2'd1, 2'd0, 2'd2, 2'd2, 2'd0, 2'd2, 2'd1};

  logic signed [31:0] d [3][3];
  gwd_pkg::comp_t     vin [3][3];

  always_comb begin
    d[0][0] = tensor.xx; d[0][1] = tensor.xy; d[0][2] = tensor.xz;
    d[1][0] = tensor.xy; d[1][1] = tensor.yy; d[1][2] = tensor.yz;
    d[2][0] = tensor.xz; d[2][1] = tensor.yz; d[2][2] = tensor.zz;
    vin[0] = vx;
    vin[1] = vy;
    vin[2] = vz;
  end

  logic v1, v2, v3, v4, v5, v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2;
      v4 <= v3; v5 <= v4; v6 <= v5;
      out_valid <= v6;
    end
  end

  // Row products D[i][j] * V[j]
  logic signed [64:0] pm [3][3][3];
  logic signed [33:0] m  [3][3][3];
  gwd_pkg::comp_t     vec1 [3][3];
  gwd_pkg::comp_t     vec2 [3][3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pm[a][i][j] = 65'(d[i][j]) * 65'(vin[a][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            m[a][i][j] <= pm[a][i][j][63:30];
          end
        end
      end
      vec1 <= vin;
    end
  end

  // Row sums D.V
  logic signed [35:0] dv [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 3; i++) begin
          dv[a][i] <= 36'(m[a][i][0]) + 36'(m[a][i][1]) + 36'(m[a][i][2]);
        end
      end
      vec2 <= vec1;
    end
  end

  // Component products a[i] * (D.b)[i]
  logic signed [68:0] pp [9][3];
  logic signed [36:0] p  [9][3];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      for (int i = 0; i < 3; i++) begin
        pp[k][i] = 69'(vec2[PA[k]][i]) * 69'(dv[PB[k]][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        for (int i = 0; i < 3; i++) begin
          p[k][i] <= pp[k][i][66:30];
        end
      end
    end
  end

  // Per-component combine: plus, cross, breathing, longitudinal, vx, vy
  logic signed [37:0] e [6][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e[0][i] <= 38'(p[0][i]) - 38'(p[1][i]);
        e[1][i] <= 38'(p[2][i]) + 38'(p[3][i]);
        e[2][i] <= 38'(p[0][i]) + 38'(p[1][i]);
        e[3][i] <= 38'(p[4][i]);
        e[4][i] <= 38'(p[5][i]) + 38'(p[6][i]);
        e[5][i] <= 38'(p[7][i]) + 38'(p[8][i]);
      end
    end
  end

  logic signed [39:0] f [6];
  logic signed [31:0] s [6];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 6; n++) begin
        f[n] <= 40'(e[n][0]) + 40'(e[n][1]) + 40'(e[n][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 6; n++) begin
        s[n] <= gwd_pkg::sat32(f[n]);
      end
    end
  end

  // Scale longitudinal by sqrt2
  logic signed [63:0] pl;
  logic signed [33:0] ql;

  assign pl = 64'(gwd_pkg::SQRT2_Q30) * 64'(s[3]);
  assign ql = pl[63:30];

  always_ff @(posedge clk) begin
    if (en) begin
      result.resp_plus         <= s[0];
      result.resp_cross        <= s[1];
      result.resp_breathing    <= s[2];
      result.resp_longitudinal <= gwd_pkg::sat32(40'(ql));
      result.resp_vector_x     <= s[4];
      result.resp_vector_y     <= s[5];
    end
  end

endmodule
